FILE: design/packed_image_difference_decoder_core_assert.svh
// Assertion macros for the packed image difference decoder.
`ifndef PACKED_IMAGE_DIFFERENCE_DECODER_CORE_ASSERT_SVH
`define PACKED_IMAGE_DIFFERENCE_DECODER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PIDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define PIDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/pidd_pkg.sv
// Shared types and constants of the packed image difference decoder.
package pidd_pkg;
  localparam int unsigned PixW = 16;
  localparam int unsigned CntW = 4;

  // Widest row the history ring holds, and pixels per output group.
  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned GroupPixels = 8;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t [7:0]    pix;
    logic [CntW-1:0] count;
    logic          last;
    logic          done;
  } grp_t;

  function automatic logic [5:0] width_of(input logic [2:0] code);
    logic [5:0] w;
    unique case (code)
      3'd0: w = 6'd0;
      3'd1: w = 6'd4;
      3'd2: w = 6'd5;
      3'd3: w = 6'd6;
      3'd4: w = 6'd7;
      3'd5: w = 6'd8;
      3'd6: w = 6'd16;
      default: w = 6'd32;
    endcase
    return w;
  endfunction

  localparam logic [12:0] WidthReset  = 13'd3450;
  localparam logic [12:0] HeightReset = 13'd3450;
  localparam logic [0:0]  RegWidth    = 1'b0;
  localparam logic [0:0]  RegHeight   = 1'b1;
endpackage

FILE: design/pidd_if.sv
// Valid/ready channel interfaces for bytes and pixel groups.
interface pidd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  modport source (output valid, output packed_byte, input ready);
  modport sink (input valid, input packed_byte, output ready);
endinterface

interface pidd_grp_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_a;
  logic [15:0] pixel_b;
  logic [15:0] pixel_c;
  logic [15:0] pixel_d;
  logic [15:0] pixel_e;
  logic [15:0] pixel_f;
  logic [15:0] pixel_g;
  logic [15:0] pixel_h;
  logic [3:0]  pixel_count;
  logic        group_last;
  logic        image_done;
  modport source (output valid, output pixel_a, output pixel_b, output pixel_c,
                  output pixel_d, output pixel_e, output pixel_f, output pixel_g,
                  output pixel_h, output pixel_count, output group_last,
                  output image_done, input ready);
  modport sink (input valid, input pixel_a, input pixel_b, input pixel_c,
                input pixel_d, input pixel_e, input pixel_f, input pixel_g,
                input pixel_h, input pixel_count, input group_last,
                input image_done, output ready);
endinterface

FILE: design/pidd_hist_mem.sv
// Row history memory: one write port, one read port, registered read data.
module pidd_hist_mem #(
  parameter int unsigned Depth = 4097,
  parameter int unsigned AddrW = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);
  logic [15:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/packed_image_difference_decoder_core.sv
// Packed image difference decoder: top level with bit parser and predictor.
//
// Bytes of the packed body arrive on the in channel (valid/ready), one per
// request. Decoded 16-bit pixels leave on the out channel in groups of up
// to eight; pixel_count tells how many are valid, group_last marks the last
// group a byte caused and image_done the group holding the final pixel.
// image_width and image_height are written on the APB port; the user
// must do so only while idle, the block does not enforce it. A byte is
// taken only when the previous one is fully processed. A pixel in the
// first row, or the first of the second row, is finished at once; later
// pixels wait while the four neighbors are read one by one through the
// single read port of the history memory. A byte that arrives after the
// last pixel is accepted and dropped; any other byte passes through accept,
// window load, the step that finds the window short and flush, and
// takes longest for runs of zero-width fields. When a group is full the
// parser waits until the output register is free, so a stalled receiver
// stops decoding without loss. Reset clears all control state; the history
// memory is not cleared and only entries already written are ever read.
// After the last pixel all further bytes are accepted and dropped.
module packed_image_difference_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pidd_byte_if.sink   in_if,
  pidd_grp_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned MaxWidth    = pidd_pkg::MaxWidth;
  localparam int unsigned GroupPixels = pidd_pkg::GroupPixels;
  localparam int unsigned Depth = MaxWidth + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned GcW   = $clog2(GroupPixels + 1);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001, StRun  = 7'b0000010, StRdA = 7'b0000100,
    StRdB  = 7'b0001000, StRdC  = 7'b0010000, StRdD = 7'b0100000,
    StFlush = 7'b1000000
  } st_e;

  st_e st_q, st_d;
  logic [12:0] width_q, height_q;
  logic [31:0] win_q, win_d;
  logic [5:0]  fill_q, fill_d;
  logic [7:0]  spill_q, spill_d;
  logic [3:0]  sfill_q, sfill_d;
  logic [7:0]  runrem_q, runrem_d;
  logic [5:0]  fw_q, fw_d;
  logic        inrun_q, inrun_d;
  logic [24:0] pidx_q, pidx_d;
  logic [AddrW-1:0] ptr_q, ptr_d;   // pidx mod Depth
  logic [15:0] diff_q, diff_d;
  logic signed [18:0] acc_q, acc_d;
  pidd_pkg::pix_t [7:0] grp_q, grp_d;
  logic [GcW-1:0] gn_q, gn_d;
  logic        ov_q;
  pidd_pkg::grp_t og_q;
  logic        emit;
  pidd_pkg::grp_t eg;
  logic [15:0] prev_q;   // last decoded pixel, the left neighbor of the next one

  logic [12:0] w_eff;
  logic [25:0] total;
  logic        img_done;

  assign w_eff = (width_q > 13'(MaxWidth)) ? 13'(MaxWidth) : width_q;
  assign total = 26'(w_eff) * 26'(height_q);
  assign img_done = {1'b0, pidx_q} >= total;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == pidd_pkg::RegHeight) prdata = {19'd0, height_q};
    else prdata = {19'd0, width_q};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pidd_pkg::WidthReset;
      height_q <= pidd_pkg::HeightReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2] == pidd_pkg::RegWidth) width_q <= pwdata[12:0];
      else height_q <= pwdata[12:0];
    end
  end

  // History memory
  logic             h_we;
  logic [AddrW-1:0] h_raddr;
  logic [15:0]      h_rdata;
  logic [15:0]      h_wdata;
  pidd_hist_mem #(.Depth(Depth), .AddrW(AddrW)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(ptr_q), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  function automatic logic [AddrW-1:0] back(input logic [AddrW-1:0] p,
                                            input logic [13:0] d);
    logic [AddrW:0] s;
    s = {1'b0, p} + (AddrW+1)'(Depth) - (AddrW+1)'(d);
    if (s >= (AddrW+1)'(Depth)) s = s - (AddrW+1)'(Depth);
    return s[AddrW-1:0];
  endfunction

  logic out_free;
  assign out_free = !ov_q || out_if.ready;
  assign in_if.ready = (st_q == StIdle);

  logic [31:0] raw;
  logic [15:0] pval;
  logic        pix_now;
  logic signed [18:0] qsum;

  always_comb begin
    st_d = st_q; win_d = win_q; fill_d = fill_q; spill_d = spill_q;
    sfill_d = sfill_q; runrem_d = runrem_q; fw_d = fw_q; inrun_d = inrun_q;
    pidx_d = pidx_q; ptr_d = ptr_q; diff_d = diff_q; acc_d = acc_q;
    grp_d = grp_q; gn_d = gn_q;
    emit = 1'b0; eg = '0; h_we = 1'b0; h_wdata = 16'd0; h_raddr = back(ptr_q, 14'd1);
    raw = 32'd0; pval = 16'd0; pix_now = 1'b0; qsum = '0;
    unique case (st_q)
      StIdle: begin
        if (in_if.valid && !img_done) begin
          spill_d = in_if.packed_byte;
          sfill_d = 4'd8;
          st_d = StRun;
        end
      end
      StRun: begin
        if (img_done) begin
          st_d = StFlush;
        end else if (!inrun_q) begin
          if (fill_q < 6'd6) begin
            if (sfill_q == 4'd0) st_d = StFlush;
            else begin
              win_d = win_q | (32'(spill_q) << fill_q);
              fill_d = fill_q + 6'(sfill_q);
              sfill_d = 4'd0;
            end
          end else begin
            runrem_d = 8'd1 << win_q[2:0];
            fw_d = pidd_pkg::width_of(win_q[5:3]);
            win_d = win_q >> 6;
            fill_d = fill_q - 6'd6;
            inrun_d = 1'b1;
          end
        end else if (runrem_q == 8'd0) begin
          inrun_d = 1'b0;
        end else if (fill_q < fw_q) begin
          if (sfill_q == 4'd0) st_d = StFlush;
          else begin
            win_d = win_q | (32'(spill_q) << fill_q);
            if ((7'd32 - 7'(fill_q)) > 7'(sfill_q)) begin
              fill_d = fill_q + 6'(sfill_q);
              sfill_d = 4'd0;
            end else begin
              spill_d = 8'(16'(spill_q) >> (6'd32 - fill_q));
              sfill_d = sfill_q - 4'(6'd32 - fill_q);
              fill_d = 6'd32;
            end
          end
        end else if (gn_q < GcW'(GroupPixels) || out_free) begin
          // Take the field, then either finish the pixel now or fetch neighbours.
          if (fw_q != 6'd0) begin
            raw = (fw_q == 6'd32) ? win_q : (win_q & ((32'd1 << fw_q) - 32'd1));
            if (fw_q != 6'd32 && raw[5'(fw_q - 6'd1)]) raw = raw | ~((32'd1 << fw_q) - 32'd1);
            fill_d = fill_q - fw_q;
            win_d = (fw_q == 6'd32) ? 32'd0 : (win_q >> fw_q);
          end
          runrem_d = runrem_q - 8'd1;
          if (runrem_q == 8'd1) inrun_d = 1'b0;
          diff_d = raw[15:0];
          if ({1'b0, pidx_q} > 26'(w_eff)) begin
            h_raddr = back(ptr_q, 14'd1);
            st_d = StRdA;
            acc_d = 19'sd2;
          end else begin
            pix_now = 1'b1;
            pval = (pidx_q == 25'd0) ? raw[15:0] : 16'(prev_q + raw[15:0]);
          end
        end
      end
      StRdA: begin
        h_raddr = back(ptr_q, 14'(w_eff));
        acc_d = acc_q + 19'(signed'(h_rdata));
        st_d = StRdB;
      end
      StRdB: begin
        h_raddr = back(ptr_q, 14'(w_eff) + 14'd1);
        acc_d = acc_q + 19'(signed'(h_rdata));
        st_d = StRdC;
      end
      StRdC: begin
        h_raddr = back(ptr_q, 14'(w_eff) - 14'd1);
        acc_d = acc_q + 19'(signed'(h_rdata));
        st_d = StRdD;
      end
      StRdD: begin
        qsum = (w_eff != 13'd1) ? acc_q + 19'(signed'(h_rdata)) : acc_q;
        qsum = (qsum < 0) ? -((-qsum) >>> 2) : (qsum >>> 2);
        pval = 16'(diff_q + qsum[15:0]);
        pix_now = 1'b1;
        st_d = StRun;
      end
      StFlush: begin
        if (out_free) begin
          if (gn_q != '0) begin
            emit = 1'b1;
            eg.count = 4'(gn_q);
            eg.last = 1'b1;
            eg.done = img_done;
            for (int i = 0; i < 8; i++) eg.pix[i] = (i < int'(gn_q)) ? grp_q[i] : 16'd0;
          end
          gn_d = '0;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase

    if (pix_now) begin
      h_we = 1'b1;
      h_wdata = pval;
      pidx_d = pidx_q + 25'd1;
      ptr_d = (ptr_q == AddrW'(Depth - 1)) ? '0 : ptr_q + AddrW'(1);
      // A full group goes out when the next pixel is decoded, which starts a new group.
      if (gn_q == GcW'(GroupPixels)) begin
        emit = 1'b1;
        eg.count = 4'(GroupPixels);
        eg.last = 1'b0;
        eg.done = 1'b0;
        for (int i = 0; i < 8; i++) eg.pix[i] = (i < GroupPixels) ? grp_q[i] : 16'd0;
        grp_d[0] = pval;
        gn_d = GcW'(1);
      end else begin
        grp_d[gn_q[2:0]] = pval;
        gn_d = gn_q + GcW'(1);
      end
    end
  end

  // A full group held back here waits for the byte's flush or the next pixel;
  // the flush marks it last, which matches groups emitted on completion.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; win_q <= '0; fill_q <= '0; spill_q <= '0; sfill_q <= '0;
      runrem_q <= '0; fw_q <= '0; inrun_q <= 1'b0; pidx_q <= '0; ptr_q <= '0;
      gn_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; win_q <= win_d; fill_q <= fill_d; spill_q <= spill_d;
      sfill_q <= sfill_d; runrem_q <= runrem_d; fw_q <= fw_d; inrun_q <= inrun_d;
      pidx_q <= pidx_d; ptr_q <= ptr_d; gn_q <= gn_d;
      if (emit) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    acc_q <= acc_d;
    grp_q <= grp_d;
    if (emit) og_q <= eg;
    if (pix_now) prev_q <= pval;
  end

  assign out_if.valid = ov_q;
  assign out_if.pixel_a = og_q.pix[0];
  assign out_if.pixel_b = og_q.pix[1];
  assign out_if.pixel_c = og_q.pix[2];
  assign out_if.pixel_d = og_q.pix[3];
  assign out_if.pixel_e = og_q.pix[4];
  assign out_if.pixel_f = og_q.pix[5];
  assign out_if.pixel_g = og_q.pix[6];
  assign out_if.pixel_h = og_q.pix[7];
  assign out_if.pixel_count = og_q.count;
  assign out_if.group_last = og_q.last;
  assign out_if.image_done = og_q.done;

  `include "packed_image_difference_decoder_core_assert.svh"

  `PIDD_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, ov_q && !out_if.ready, !emit,
                    "output group overwritten while stalled")
  `PIDD_ASSERT_IMPL(a_group_bound, clk_i, rst_ni, 1'b1, gn_q <= GcW'(GroupPixels),
                    "group count out of range")
  `PIDD_ASSERT_NEXT(a_idle_after_flush, clk_i, rst_ni,
                    st_q == StFlush && out_free, st_q == StIdle,
                    "flush did not return to idle")
endmodule

FILE: bench/packed_image_difference_decoder_core_tb.sv
// Self-checking testbench of the packed image difference decoder core.
module packed_image_difference_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HistDepth = 4097;
  localparam int unsigned WidthCap = 4096;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 64;
  localparam logic [2:0] WidthAddr = {pidd_pkg::RegWidth, 2'b00};
  localparam logic [2:0] HeightAddr = {pidd_pkg::RegHeight, 2'b00};
  localparam int unsigned FieldBits [8] = '{0, 4, 5, 6, 7, 8, 16, 32};
  localparam logic [7:0] EdgeBytes [13] = '{8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hAA,
                                            8'h55, 8'hC0, 8'h3F, 8'h07, 8'hF8, 8'h00,
                                            8'hFF};

  typedef struct {
    logic [7:0]     value;
    bit             typed;
    pidd_pkg::grp_t first_group;
  } byte_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pidd_byte_if byte_ch ();
  pidd_grp_if  grp_ch ();

  packed_image_difference_decoder_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (byte_ch),
    .out_if  (grp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Decoder state mirrored by the testbench.
  int unsigned img_width;
  int unsigned img_height;
  logic [31:0] window;
  int unsigned window_bits;
  int unsigned run_left;
  int unsigned field_bits;
  bit          run_open;
  int unsigned pixel_pos;
  logic [15:0] line_store [HistDepth];

  pidd_pkg::grp_t pending_groups [$];
  int   error_count;
  int unsigned quiet_cycles = 0;
  bit   hold_request;
  bit   no_idling;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Decodes one accepted byte and queues the pixel groups it produces.
  task automatic decode_byte(input logic [7:0] b);
    int unsigned eff_width;
    int unsigned pixel_total;
    logic [31:0] spill;
    int unsigned spill_bits;
    logic [31:0] raw;
    logic [31:0] mask;
    logic [15:0] val;
    int          s;
    int unsigned p;
    int unsigned gn;
    pidd_pkg::grp_t g;
    pidd_pkg::grp_t made [$];
    eff_width = (img_width > WidthCap) ? WidthCap : img_width;
    pixel_total = eff_width * img_height;
    if (pixel_pos >= pixel_total) return;
    spill = {24'd0, b};
    spill_bits = 8;
    gn = 0;
    g = '0;
    while (pixel_pos < pixel_total) begin
      if (!run_open) begin
        if (window_bits < 6) begin
          if (spill_bits == 0) break;
          window |= spill << window_bits;
          window_bits += spill_bits;
          spill_bits = 0;
        end else begin
          run_left = 1 << window[2:0];
          window = window >> 3;
          field_bits = FieldBits[window[2:0]];
          window = window >> 3;
          window_bits -= 6;
          run_open = 1'b1;
        end
      end else if (run_left == 0) begin
        run_open = 1'b0;
      end else if (window_bits < field_bits) begin
        if (spill_bits == 0) break;
        window |= spill << window_bits;
        if (32 - window_bits > spill_bits) begin
          window_bits += spill_bits;
          spill_bits = 0;
        end else begin
          spill = spill >> (32 - window_bits);
          spill_bits -= 32 - window_bits;
          window_bits = 32;
        end
      end else begin
        raw = '0;
        if (field_bits != 0) begin
          mask = (field_bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << field_bits) - 1);
          raw = window & mask;
          window_bits -= field_bits;
          window = (field_bits >= 32) ? 32'd0 : (window >> field_bits);
          if (field_bits < 32 && raw[field_bits-1]) raw |= ~mask;
        end
        run_left--;
        if (run_left == 0) run_open = 1'b0;
        p = pixel_pos;
        if (p > eff_width) begin
          // Rounded mean of left, upper-left, upper and upper-right.
          s = int'($signed(line_store[(p - 1) % HistDepth]))
            + int'($signed(line_store[(p - eff_width) % HistDepth]))
            + int'($signed(line_store[(p - eff_width - 1) % HistDepth]));
          if (eff_width != 1) s += int'($signed(line_store[(p - eff_width + 1) % HistDepth]));
          s += 2;
          val = raw[15:0] + 16'(s / 4);
        end else if (p != 0) begin
          val = line_store[(p - 1) % HistDepth] + raw[15:0];
        end else begin
          val = raw[15:0];
        end
        line_store[p % HistDepth] = val;
        pixel_pos++;
        g.pix[gn] = val;
        gn++;
        if (gn == 8) begin
          g.count = 4'd8;
          g.done = (pixel_pos >= pixel_total);
          made.insert(made.size(), g);
          g = '0;
          gn = 0;
        end
      end
    end
    if (gn > 0) begin
      g.count = gn[3:0];
      g.done = (pixel_pos >= pixel_total);
      made.insert(made.size(), g);
    end
    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) pending_groups.insert(pending_groups.size(), made[i]);
  endtask

  task automatic reg_write(input logic [2:0] addr, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (addr == WidthAddr) img_width = value & 32'h1FFF;
    else img_height = value & 32'h1FFF;
  endtask

  // Lets the block drain before its registers are touched.
  task automatic drain;
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_groups.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_image(input int unsigned w, input int unsigned h);
    drain();
    reg_write(WidthAddr, w);
    reg_write(HeightAddr, h);
  endtask

  // Offers one byte and holds it until taken; optionally idles afterwards.
  task automatic send_byte(input logic [7:0] b, input bit may_idle);
    byte_ch.valid <= 1'b1;
    byte_ch.packed_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    decode_byte(b);
    if (may_idle && !no_idling && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] random_byte();
    // A quarter of the bytes favor zero-width headers, which give long runs.
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_byte(random_byte(), 1'b1);
  endtask

  task automatic run_directed;
    byte_row_t rows [$];
    byte_row_t r;
    pidd_pkg::grp_t got;
    // After reset with width one: a one-pixel run of zero width gives pixel 0.
    r.value = 8'h00;
    r.typed = 1'b1;
    r.first_group = '0;
    r.first_group.count = 4'd1;
    r.first_group.last = 1'b1;
    rows.insert(rows.size(), r);
    r.typed = 1'b0;
    foreach (FieldBits[c]) begin
      r.value = 8'((c << 3) | (c % 4));
      rows.insert(rows.size(), r);
    end
    foreach (EdgeBytes[i]) begin
      r.value = EdgeBytes[i];
      rows.insert(rows.size(), r);
    end
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        byte_ch.valid <= 1'b1;
        byte_ch.packed_byte <= rows[i].value;
        do @(posedge clk_i); while (!byte_ch.ready);
        decode_byte(rows[i].value);
        got = pending_groups.pop_back();
        pending_groups.insert(pending_groups.size(), rows[i].first_group);
        if (got != rows[i].first_group) begin
          $display("%0t: table row %0d expected %h got %h", $time, i,
                   rows[i].first_group, got);
          error_count++;
        end
      end else begin
        send_byte(rows[i].value, 1'b1);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_ch.valid = 1'b0;
    byte_ch.packed_byte = '0;
    img_width = pidd_pkg::WidthReset;
    img_height = pidd_pkg::HeightReset;
    window = '0;
    window_bits = 0;
    run_left = 0;
    field_bits = 0;
    run_open = 1'b0;
    pixel_pos = 0;
    error_count = 0;
    hold_request = 1'b0;
    no_idling = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_image(1, 4096);
    run_directed();

    // Finish the image, then offer bytes that must be dropped.
    set_image(64, (pixel_pos / 64 + 2 > 8191) ? 8191 : pixel_pos / 64 + 2);
    for (int i = 0; i < 150 && pixel_pos < img_width * img_height; i++)
      send_byte(random_byte(), 1'b1);
    send_random(8);

    // Empty image: everything is dropped.
    set_image(0, img_height);
    send_random(4);

    // Width beyond the maximum is clamped; the receiver holds off meanwhile.
    set_image(8191, (pixel_pos / 4096 + 3 > 8191) ? 8191 : pixel_pos / 4096 + 3);
    hold_request = 1'b1;
    send_random(80);

    set_image(7, (pixel_pos / 7 + 2000 > 8191) ? 8191 : pixel_pos / 7 + 2000);
    send_random(75);
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_groups.size() != 0) @(posedge clk_i);
    send_random(75);

    set_image(4096, 4096);
    send_random(90);
    no_idling = 1'b1;
    send_random(60);

    drain();
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    grp_ch.ready = 1'b0;
    forever begin
      if (hold_request) begin
        grp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!no_idling && $urandom_range(0, 3) == 0) begin
        grp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        grp_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    pidd_pkg::grp_t got;
    pidd_pkg::grp_t exp_g;
    if (grp_ch.valid && grp_ch.ready && rst_ni) begin
      got.pix = {grp_ch.pixel_h, grp_ch.pixel_g, grp_ch.pixel_f, grp_ch.pixel_e,
                 grp_ch.pixel_d, grp_ch.pixel_c, grp_ch.pixel_b, grp_ch.pixel_a};
      got.count = grp_ch.pixel_count;
      got.last = grp_ch.group_last;
      got.done = grp_ch.image_done;
      if (pending_groups.size() == 0) begin
        $display("%0t: unexpected group, expected none, got count %0d", $time, got.count);
        error_count++;
      end else begin
        exp_g = pending_groups.pop_front();
        for (int i = 0; i < 8; i++)
          if (got.pix[i] !== exp_g.pix[i]) begin
            $display("%0t: pixel %0d expected %h got %h", $time, i, exp_g.pix[i], got.pix[i]);
            error_count++;
          end
        if (got.count !== exp_g.count) begin
          $display("%0t: pixel_count expected %0d got %0d", $time, exp_g.count, got.count);
          error_count++;
        end
        if (got.last !== exp_g.last) begin
          $display("%0t: group_last expected %b got %b", $time, exp_g.last, got.last);
          error_count++;
        end
        if (got.done !== exp_g.done) begin
          $display("%0t: image_done expected %b got %b", $time, exp_g.done, got.done);
          error_count++;
        end
      end
    end
    if ((grp_ch.valid && grp_ch.ready) || (byte_ch.valid && byte_ch.ready) || psel)
      quiet_cycles <= 0;
    else if (quiet_cycles >= StallLimit) begin
      $display("%0t: timeout, nothing moved", $time);
      $display("*** FAILED ***");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end
endmodule
